@@ hw/rtl/scrt_pkg.sv @@
// ----------------------------------------------------------------------------
// scrt_pkg
// Shared widths and types for the sorted colour remap table.
// ----------------------------------------------------------------------------
package scrt_pkg;

	localparam int unsigned Entries = 64;
	localparam int unsigned IdxW    = $clog2(Entries);
	localparam int unsigned CntW    = $clog2(Entries + 1);
	localparam int unsigned ColW    = 32;
	localparam int unsigned PairW   = 2 * ColW;

	typedef enum logic {
		REQ_ADD    = 1'b0,
		REQ_LOOKUP = 1'b1
	} req_t;

endpackage

@@ hw/rtl/scrt_ram.sv @@
// ----------------------------------------------------------------------------
// scrt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module scrt_ram #(
	parameter int unsigned Width = 8,
	parameter int unsigned Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/sorted_colour_remap_table_core.sv @@
// ----------------------------------------------------------------------------
// sorted_colour_remap_table_core
// Sorted (old colour, new colour) pair table in one RAM, with insert and
// first-match lookup.
// ----------------------------------------------------------------------------
//  channel | direction | fields
//  in      | input     | req_type, old_colour, new_colour
//  out     | output    | hit, mapped_colour, status
//
// One transaction at a time. Lookup: reads entries in order from entry 0 and
// stops at a match, at a larger old colour or at the last entry; an empty
// table answers a miss without a scan. Add: scan to the slot, one set-up read,
// one shift per entry moved up, one write of the new pair; an appended pair
// or an empty table skips the shift. An add on a full table is dropped with status set.
// Reset clears the entry count and the registers, not the RAM contents;
// a stalled result holds in the output register and blocks the next one.
module sorted_colour_remap_table_core
	import scrt_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            req_type,
	input  logic [ColW-1:0] old_colour,
	input  logic [ColW-1:0] new_colour,
	output logic            out_valid,
	input  logic            out_ready,
	output logic            hit,
	output logic [ColW-1:0] mapped_colour,
	output logic            status
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_PREP, ST_SHIFT, ST_PUT, ST_DONE
	} state_t;

	state_t            state_q;
	logic [CntW-1:0]   count_q;
	logic [CntW-1:0]   ptr_q;     // scan index of the word in rdata; insert slot
	logic [CntW-1:0]   pos_q;     // shift target / write address
	logic              req_q;
	logic [PairW-1:0]  pair_q;

	logic              we;
	logic [IdxW-1:0]   waddr;
	logic [PairW-1:0]  wdata;
	logic [IdxW-1:0]   raddr;
	logic [PairW-1:0]  rdata;

	scrt_ram #(.Width(PairW), .Depth(Entries)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	logic [ColW-1:0] rd_old;
	logic            accept;
	logic            last_entry;
	assign rd_old     = rdata[PairW-1:ColW];
	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign last_entry = (ptr_q + CntW'(1) == count_q);

	always_comb begin
		we    = 1'b0;
		waddr = pos_q[IdxW-1:0];
		wdata = rdata;
		raddr = '0;
		unique case (state_q)
			ST_SCAN: begin
				raddr = IdxW'(ptr_q + CntW'(1));
			end
			ST_PREP: begin
				raddr = IdxW'(count_q - CntW'(1));
			end
			ST_SHIFT: begin
				// rdata holds entry pos_q-1, move it up to pos_q
				we    = 1'b1;
				raddr = IdxW'(pos_q - CntW'(2));
			end
			ST_PUT: begin
				we    = 1'b1;
				wdata = pair_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			count_q       <= '0;
			out_valid     <= 1'b0;
			ptr_q         <= '0;
			pos_q         <= '0;
			req_q         <= 1'b0;
			pair_q        <= '0;
			hit           <= 1'b0;
			mapped_colour <= '0;
			status        <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						req_q         <= req_type;
						pair_q        <= {old_colour, new_colour};
						ptr_q         <= '0;
						pos_q         <= '0;
						hit           <= 1'b0;
						mapped_colour <= '0;
						status        <= 1'b0;
						if (req_type == REQ_ADD && count_q == CntW'(Entries)) begin
							status    <= 1'b1;
							out_valid <= 1'b1;
							state_q   <= ST_DONE;
						end else if (count_q == '0) begin
							if (req_type == REQ_ADD) begin
								state_q <= ST_PUT;
							end else begin
								out_valid <= 1'b1;
								state_q   <= ST_DONE;
							end
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// rdata = entry ptr_q
					if (req_q == REQ_LOOKUP) begin
						if (rd_old == pair_q[PairW-1:ColW]) begin
							hit           <= 1'b1;
							mapped_colour <= rdata[ColW-1:0];
							out_valid     <= 1'b1;
							state_q       <= ST_DONE;
						end else if (rd_old > pair_q[PairW-1:ColW] || last_entry) begin
							out_valid <= 1'b1;
							state_q   <= ST_DONE;
						end else begin
							ptr_q <= ptr_q + CntW'(1);
						end
					end else begin
						if (rdata > pair_q) begin
							pos_q   <= count_q;
							state_q <= ST_PREP;
						end else if (last_entry) begin
							pos_q   <= count_q;
							state_q <= ST_PUT;
						end else begin
							ptr_q <= ptr_q + CntW'(1);
						end
					end
				end
				ST_PREP: begin
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					pos_q <= pos_q - CntW'(1);
					if (pos_q - CntW'(1) == ptr_q) begin
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					count_q   <= count_q + CntW'(1);
					out_valid <= 1'b1;
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Entries))
		else $error("entry count overflow");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUT) |=> (count_q == $past(count_q) + CntW'(1)))
		else $error("insert did not advance count");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == ST_DONE))
		else $error("result shown outside done state");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> !status)
		else $error("hit and full flag together");

endmodule

@@ sim/sorted_colour_remap_table_core_tb.sv @@
// ----------------------------------------------------------------------------
// sorted_colour_remap_table_core_tb
// Drives add and lookup transactions into the sorted colour remap table with
// bursty input and a stalling output, predicts each result from a local
// sorted pair list, and compares every result field by field in order.
// ----------------------------------------------------------------------------
module sorted_colour_remap_table_core_tb
	import scrt_pkg::*;
;

	localparam int WatchLimit = 20000;

	typedef struct packed {
		logic            hit;
		logic [ColW-1:0] mapped;
		logic            status;
	} remap_result_t;

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	logic            req_type;
	logic [ColW-1:0] old_colour;
	logic [ColW-1:0] new_colour;
	logic            out_valid;
	logic            out_ready;
	logic            hit;
	logic [ColW-1:0] mapped_colour;
	logic            status;

	logic [PairW-1:0] pair_list[$];
	remap_result_t    expected_results[$];
	logic [ColW-1:0]  key_pool[$];
	int               errors;
	int               sent_items;
	int               got_results;
	int               lookup_hits;
	int               full_drops;
	int               idle_cycles;
	bit               hold_off;
	bit               no_gaps;

	sorted_colour_remap_table_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .old_colour(old_colour), .new_colour(new_colour),
		.out_valid(out_valid), .out_ready(out_ready),
		.hit(hit), .mapped_colour(mapped_colour), .status(status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic remap_result_t predict_remap(req_t req, logic [ColW-1:0] from,
		logic [ColW-1:0] to);
		remap_result_t r;
		logic [PairW-1:0] pr;
		int pos;
		r = '0;
		pr = {from, to};
		if (req == REQ_ADD) begin
			if (pair_list.size() >= Entries) begin
				r.status = 1'b1;
			end else begin
				pos = 0;
				while (pos < pair_list.size() && pair_list[pos] <= pr) pos++;
				pair_list.insert(pos, pr);
			end
		end else begin
			foreach (pair_list[i]) begin
				if (pair_list[i][PairW-1:ColW] == from) begin
					r.hit = 1'b1;
					r.mapped = pair_list[i][ColW-1:0];
					break;
				end
				if (pair_list[i][PairW-1:ColW] > from) break;
			end
		end
		return r;
	endfunction

	task automatic send_item(req_t req, logic [ColW-1:0] from, logic [ColW-1:0] to);
		remap_result_t r;
		in_valid <= 1'b1;
		req_type <= req;
		old_colour <= from;
		new_colour <= to;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = predict_remap(req, from, to);
		if (req == REQ_LOOKUP && r.hit) lookup_hits++;
		if (r.status) full_drops++;
		expected_results.insert(expected_results.size(), r);
		sent_items++;
		if (!no_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic logic [ColW-1:0] pick_key();
		if (key_pool.size() != 0 && $urandom_range(0, 3) != 0)
			return key_pool[$urandom_range(0, key_pool.size() - 1)];
		return $urandom();
	endfunction

	task automatic test_empty_and_extremes();
		send_item(REQ_LOOKUP, 32'h0, 32'h0);
		send_item(REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(REQ_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(REQ_ADD, 32'h0, 32'h0);
		send_item(REQ_ADD, 32'h0, 32'hFFFF_FFFF);
		send_item(REQ_ADD, 32'h8000_0000, 32'h1234_5678);
		send_item(REQ_LOOKUP, 32'h0, 32'hA5A5_A5A5);
		send_item(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0);
		send_item(REQ_LOOKUP, 32'h8000_0000, 32'h0);
		send_item(REQ_LOOKUP, 32'h7FFF_FFFF, 32'h0);
	endtask

	task automatic test_duplicates();
		send_item(REQ_ADD, 32'h1020_3040, 32'h9000_0000);
		send_item(REQ_ADD, 32'h1020_3040, 32'h0000_0001);
		send_item(REQ_ADD, 32'h1020_3040, 32'h0000_0001);
		send_item(REQ_LOOKUP, 32'h1020_3040, 32'h0);
		send_item(REQ_ADD, 32'h1020_3040, 32'h0000_0000);
		send_item(REQ_LOOKUP, 32'h1020_3040, 32'h0);
	endtask

	task automatic test_full_table();
		while (pair_list.size() < Entries) send_item(REQ_ADD, $urandom(), $urandom());
		send_item(REQ_ADD, 32'h5555_5555, 32'hAAAA_AAAA);
		send_item(REQ_ADD, 32'h0, 32'h0);
		send_item(REQ_LOOKUP, pair_list[Entries-1][PairW-1:ColW], 32'h0);
		send_item(REQ_LOOKUP, pair_list[0][PairW-1:ColW], 32'h0);
	endtask

	task automatic test_backpressure();
		no_gaps = 1'b1;
		hold_off = 1'b1;
		repeat (12) send_item(REQ_LOOKUP, pick_key(), $urandom());
		no_gaps = 1'b0;
		drain_results();
	endtask

	// fresh table each round is impossible without reset, so the full table
	// stays full; lookups dominate with keys drawn from added colours
	task automatic test_random_traffic(int n);
		logic [ColW-1:0] k;
		for (int i = 0; i < n; i++) begin
			if (pair_list.size() < Entries && $urandom_range(0, 2) == 0) begin
				k = $urandom();
				key_pool.insert(key_pool.size(), k);
				send_item(REQ_ADD, k, $urandom());
			end else if ($urandom_range(0, 9) == 0) begin
				send_item(REQ_ADD, pick_key(), $urandom());
			end else begin
				send_item(REQ_LOOKUP, pick_key(), $urandom());
			end
			if (i == n / 2) drain_results();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = 1'b0;
		old_colour = '0;
		new_colour = '0;
		errors = 0;
		sent_items = 0;
		got_results = 0;
		lookup_hits = 0;
		full_drops = 0;
		hold_off = 1'b0;
		no_gaps = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_and_extremes();
		test_duplicates();
		for (int i = 0; i < pair_list.size(); i++)
			key_pool.insert(key_pool.size(), pair_list[i][PairW-1:ColW]);
		test_random_traffic(400);
		test_full_table();
		for (int i = 0; i < pair_list.size(); i++)
			key_pool.insert(key_pool.size(), pair_list[i][PairW-1:ColW]);
		test_backpressure();
		test_random_traffic(900);
		drain_results();
		$display("%0d transactions sent, %0d results checked", sent_items, got_results);
		$display("%0d lookup hits, %0d adds dropped on a full table",
			lookup_hits, full_drops);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// output stall pattern, plus one long hold-off on request
	initial begin
		int n;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				n = 0;
				while (n < 200) begin
					out_ready <= 1'b0;
					@(posedge clk);
					n++;
				end
				hold_off = 1'b0;
			end
			case ($urandom_range(0, 3))
				0: out_ready <= 1'b0;
				1: out_ready <= ($urandom_range(0, 1) == 1);
				default: out_ready <= 1'b1;
			endcase
		end
	end

	always @(posedge clk) begin
		remap_result_t e;
		if (arst_n && out_valid && out_ready) begin
			got_results++;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result hit=%b mapped=%h status=%b",
					$time, hit, mapped_colour, status);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (hit !== e.hit) begin
					$display("%0t: hit expected %b actual %b", $time, e.hit, hit);
					errors++;
				end
				if (mapped_colour !== e.mapped) begin
					$display("%0t: mapped_colour expected %h actual %h",
						$time, e.mapped, mapped_colour);
					errors++;
				end
				if (status !== e.status) begin
					$display("%0t: status expected %b actual %b", $time, e.status, status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchLimit) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule

@@ sorted_colour_remap_table_core.f @@
hw/rtl/scrt_pkg.sv
hw/rtl/scrt_ram.sv
hw/rtl/sorted_colour_remap_table_core.sv
sim/sorted_colour_remap_table_core_tb.sv
